// ===== rtl/core/hsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hsr_pkg;

    // Phase codes as they appear on phase_now.
    localparam logic [1:0] PHASE_LISTEN  = 2'd0;
    localparam logic [1:0] PHASE_SYNRCVD = 2'd1;
    localparam logic [1:0] PHASE_EST     = 2'd2;

    // Verdict codes as they appear on verdict.
    localparam logic [2:0] VERDICT_OK       = 3'd0;
    localparam logic [2:0] VERDICT_CHECKSUM = 3'd1;
    localparam logic [2:0] VERDICT_FLAGS    = 3'd2;
    localparam logic [2:0] VERDICT_ID       = 3'd3;
    localparam logic [2:0] VERDICT_ACK      = 3'd4;
    localparam logic [2:0] VERDICT_RESENT   = 3'd5;
    localparam logic [2:0] VERDICT_GAVEUP   = 3'd6;
    localparam logic [2:0] VERDICT_IDLE     = 3'd7;

    localparam logic [3:0] PATIENCE_RESET = 4'd10;

    // One result word.
    typedef struct packed {
        logic        send_valid;
        logic        tx_syn;
        logic        tx_ack;
        logic [31:0] tx_conn_id;
        logic [31:0] tx_seq;
        logic [31:0] tx_acknum;
        logic        deliver;
        logic [1:0]  phase_now;
        logic [2:0]  verdict;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/handshake_server_responder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Server side of a three-way handshake, one header or timeout event per word.
// Input channel: in_valid / in_stall carry mode, checksum_ok, the flags and
// the three header numbers. Output channel: out_valid / out_stall carry one
// result word per input word: the header to send (if any), deliver, the
// phase after the event and a verdict.
// An accepted word's result is registered. Throughput is one word per cycle
// while in_stall is low; the decision is a few compares and two 32-bit
// increments on registered state. The output side has a main register and a
// skid register, so one more word is accepted while a result waits on a
// stalled receiver; in_stall rises only when both hold results. Results leave
// in order and hold while stalled. The user must write the patience register
// (cfg_wr_en / cfg_wr_data) only while idle; the block does not enforce it.
// Reset (rst_n low, asynchronous) returns to listen, clears the sequence
// counter, connection id, saved header and try count, sets patience to 10
// and empties both output registers.
module handshake_server_responder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic        checksum_ok,
    input  wire logic        syn_flag,
    input  wire logic        ack_flag,
    input  wire logic [31:0] peer_conn_id,
    input  wire logic [31:0] peer_seq,
    input  wire logic [31:0] peer_ack,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             send_valid,
    output logic             tx_syn,
    output logic             tx_ack,
    output logic [31:0]      tx_conn_id,
    output logic [31:0]      tx_seq,
    output logic [31:0]      tx_acknum,
    output logic             deliver,
    output logic [1:0]       phase_now,
    output logic [2:0]       verdict
);
    import hsr_pkg::*;

    typedef enum logic [1:0] {
        ST_LISTEN  = PHASE_LISTEN,
        ST_SYNRCVD = PHASE_SYNRCVD,
        ST_EST     = PHASE_EST
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] seq_counter_reg, seq_counter_next;
    logic [31:0] conn_id_reg, conn_id_next;
    logic [31:0] saved_seq_reg, saved_seq_next;
    logic [31:0] saved_acknum_reg, saved_acknum_next;
    logic [3:0]  tries_reg, tries_next;
    logic [3:0]  patience_reg;

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     main_reg;
    result_t     skid_reg;
    result_t     res;

    logic        in_accept;
    logic        out_take;
    logic [3:0]  lim;
    logic [3:0]  tries_inc;
    logic [31:0] peer_seq_inc;
    logic        fail;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = main_valid_reg && !out_stall;

    assign lim          = (patience_reg == 4'd0) ? 4'd1 : patience_reg;
    assign tries_inc    = tries_reg + 4'd1;
    assign peer_seq_inc = peer_seq + 32'd1;

    // Decision logic for one event against the registered connection state.
    always_comb
    begin
        phase_next        = phase_reg;
        seq_counter_next  = seq_counter_reg;
        conn_id_next      = conn_id_reg;
        saved_seq_next    = saved_seq_reg;
        saved_acknum_next = saved_acknum_reg;
        tries_next        = tries_reg;
        res               = '0;
        res.verdict       = VERDICT_OK;
        fail              = 1'b0;

        case (phase_reg)
            ST_SYNRCVD:
            begin
                fail = 1'b1;
                if (mode)
                begin
                    res.send_valid = 1'b1;
                    res.tx_syn     = 1'b1;
                    res.tx_ack     = 1'b1;
                    res.tx_conn_id = conn_id_reg;
                    res.tx_seq     = saved_seq_reg;
                    res.tx_acknum  = saved_acknum_reg;
                    res.verdict    = VERDICT_RESENT;
                end
                else if (!checksum_ok)
                begin
                    res.verdict = VERDICT_CHECKSUM;
                end
                else if (peer_conn_id != conn_id_reg)
                begin
                    res.verdict = VERDICT_ID;
                end
                else if (!ack_flag)
                begin
                    res.verdict = VERDICT_FLAGS;
                end
                else if (peer_ack != seq_counter_reg)
                begin
                    res.verdict = VERDICT_ACK;
                end
                else
                begin
                    fail       = 1'b0;
                    phase_next = ST_EST;
                    tries_next = 4'd0;
                end
                // Every failed event counts a try; the last one clears all.
                if (fail)
                begin
                    tries_next = tries_inc;
                    if (tries_inc >= lim)
                    begin
                        phase_next        = ST_LISTEN;
                        seq_counter_next  = 32'd0;
                        conn_id_next      = 32'd0;
                        saved_seq_next    = 32'd0;
                        saved_acknum_next = 32'd0;
                        tries_next        = 4'd0;
                        res               = '0;
                        res.verdict       = VERDICT_GAVEUP;
                    end
                end
            end
            ST_EST:
            begin
                if (mode)
                begin
                    res.verdict = VERDICT_IDLE;
                end
                else if (!checksum_ok)
                begin
                    res.verdict = VERDICT_CHECKSUM;
                end
                else if (peer_conn_id != conn_id_reg)
                begin
                    res.verdict = VERDICT_ID;
                end
                else
                begin
                    res.deliver      = 1'b1;
                    res.send_valid   = 1'b1;
                    res.tx_ack       = 1'b1;
                    res.tx_conn_id   = conn_id_reg;
                    res.tx_seq       = seq_counter_reg;
                    res.tx_acknum    = peer_seq_inc;
                    seq_counter_next = seq_counter_reg + 32'd1;
                end
            end
            default:
            begin
                // Listen, and the unused phase code handled the same way.
                if (mode)
                begin
                    res.verdict = VERDICT_IDLE;
                end
                else if (!checksum_ok)
                begin
                    res.verdict = VERDICT_CHECKSUM;
                end
                else if (!syn_flag || ack_flag)
                begin
                    res.verdict = VERDICT_FLAGS;
                end
                else
                begin
                    conn_id_next      = peer_conn_id;
                    res.send_valid    = 1'b1;
                    res.tx_syn        = 1'b1;
                    res.tx_ack        = 1'b1;
                    res.tx_conn_id    = peer_conn_id;
                    res.tx_seq        = seq_counter_reg;
                    res.tx_acknum     = peer_seq_inc;
                    seq_counter_next  = seq_counter_reg + 32'd1;
                    saved_seq_next    = seq_counter_reg;
                    saved_acknum_next = peer_seq_inc;
                    tries_next        = 4'd0;
                    phase_next        = ST_SYNRCVD;
                end
            end
        endcase
        res.phase_now = phase_next;
    end

    // Occupancy of the main and skid output registers.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_take)
        begin
            main_valid_next = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        if (in_accept)
        begin
            if (main_valid_reg && out_stall)
            begin
                skid_valid_next = 1'b1;
            end
            else
            begin
                main_valid_next = 1'b1;
            end
        end
    end

    // Connection state, patience and output occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= ST_LISTEN;
            seq_counter_reg  <= 32'd0;
            conn_id_reg      <= 32'd0;
            saved_seq_reg    <= 32'd0;
            saved_acknum_reg <= 32'd0;
            tries_reg        <= 4'd0;
            patience_reg     <= PATIENCE_RESET;
            main_valid_reg   <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg        <= phase_next;
                seq_counter_reg  <= seq_counter_next;
                conn_id_reg      <= conn_id_next;
                saved_seq_reg    <= saved_seq_next;
                saved_acknum_reg <= saved_acknum_next;
                tries_reg        <= tries_next;
            end
            if (cfg_wr_en)
            begin
                patience_reg <= cfg_wr_data;
            end
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept && main_valid_reg && out_stall)
        begin
            skid_reg <= res;
        end
        if (out_take && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
        else if (in_accept && !(main_valid_reg && out_stall))
        begin
            main_reg <= res;
        end
    end

    assign out_valid  = main_valid_reg;
    assign send_valid = main_reg.send_valid;
    assign tx_syn     = main_reg.tx_syn;
    assign tx_ack     = main_reg.tx_ack;
    assign tx_conn_id = main_reg.tx_conn_id;
    assign tx_seq     = main_reg.tx_seq;
    assign tx_acknum  = main_reg.tx_acknum;
    assign deliver    = main_reg.deliver;
    assign phase_now  = main_reg.phase_now;
    assign verdict    = main_reg.verdict;

endmodule

`default_nettype wire

// ===== rtl/core/hsr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hsr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        send_valid,
    input wire logic        tx_syn,
    input wire logic        tx_ack,
    input wire logic [31:0] tx_conn_id,
    input wire logic [31:0] tx_seq,
    input wire logic [31:0] tx_acknum,
    input wire logic        deliver,
    input wire logic [1:0]  phase_now,
    input wire logic [2:0]  verdict
);
    import hsr_pkg::*;

    // A stalled result word stays and does not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(tx_seq)
            && $stable(tx_acknum) && $stable(phase_now) && $stable(send_valid))
    else $error("stalled result word changed");

    // With nothing to send, the header fields are all zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_valid |-> !tx_syn && !tx_ack && tx_conn_id == 32'd0
            && tx_seq == 32'd0 && tx_acknum == 32'd0)
    else $error("header fields set without a header to send");

    // Delivered data is answered with a plain ACK in the established phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && deliver |-> send_valid && tx_ack && !tx_syn
            && phase_now == PHASE_EST && verdict == VERDICT_OK)
    else $error("delivery without an established ACK");

    // Giving up returns to listen and sends nothing; a resend stays in syn-received.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_GAVEUP |-> phase_now == PHASE_LISTEN && !send_valid)
    else $error("give-up did not clear the connection");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && verdict == VERDICT_RESENT |-> send_valid && tx_syn && tx_ack
            && phase_now == PHASE_SYNRCVD && !deliver)
    else $error("resend is not a SYN+ACK in syn-received");

endmodule

bind handshake_server_responder hsr_checker u_hsr_checker (.*);

`default_nettype wire

// ===== bench/handshake_server_responder_tb.sv =====
`timescale 1ns / 1ps

module handshake_server_responder_tb;

    import hsr_pkg::*;

    localparam logic [31:0] ONES = 32'hFFFF_FFFF;
    localparam int DIRECTED_ROWS = 23;
    localparam int EST_FIRST_ROW = 16;
    localparam int PHASES = 6;
    localparam logic [3:0] PATIENCE_PLAN [0:4] = '{4'd1, 4'd15, 4'd0, 4'd4, 4'd10};

    // One received header or timeout event, as driven onto the input ports.
    typedef struct packed {
        logic        mode;
        logic        checksum_ok;
        logic        syn;
        logic        ack;
        logic [31:0] conn_id;
        logic [31:0] seq;
        logic [31:0] ack_num;
    } hdr_event_t;

    // A directed row: the event word and, where typed, the reply it must give.
    typedef struct {
        hdr_event_t word;
        bit         typed;
        result_t    want;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [3:0] cfg_wr_data = 4'd0;
    logic       in_valid = 1'b0;
    logic       out_stall = 1'b0;
    hdr_event_t drv_event = '0;
    bit         drv_typed = 1'b0;
    result_t    drv_want = '0;

    wire        in_stall;
    wire        out_valid;
    wire        send_valid;
    wire        tx_syn;
    wire        tx_ack;
    wire [31:0] tx_conn_id;
    wire [31:0] tx_seq;
    wire [31:0] tx_acknum;
    wire        deliver;
    wire [1:0]  phase_now;
    wire [2:0]  verdict;

    // Server state as the testbench tracks it.
    logic [1:0]  srv_phase;
    logic [31:0] srv_seq;
    logic [31:0] srv_conn_id;
    logic [31:0] srv_saved_seq;
    logic [31:0] srv_saved_acknum;
    logic [3:0]  srv_tries;
    logic [3:0]  srv_patience;

    result_t   pending_replies [$];
    result_t   observed_reply;
    result_t   predicted_reply;
    stim_row_t directed_rows [0:DIRECTED_ROWS-1];

    int idle_pct = 26;
    int fail_count = 0;
    int words_sent = 0;
    int results_checked = 0;
    int resends_seen = 0;
    int give_ups_seen = 0;
    int delivered_seen = 0;

    handshake_server_responder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (drv_event.mode),
        .checksum_ok  (drv_event.checksum_ok),
        .syn_flag     (drv_event.syn),
        .ack_flag     (drv_event.ack),
        .peer_conn_id (drv_event.conn_id),
        .peer_seq     (drv_event.seq),
        .peer_ack     (drv_event.ack_num),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .send_valid   (send_valid),
        .tx_syn       (tx_syn),
        .tx_ack       (tx_ack),
        .tx_conn_id   (tx_conn_id),
        .tx_seq       (tx_seq),
        .tx_acknum    (tx_acknum),
        .deliver      (deliver),
        .phase_now    (phase_now),
        .verdict      (verdict)
    );

    always #5 clk = ~clk;

    // The receiver stalls at random on the falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    function automatic hdr_event_t make_event(input logic m, input logic c, input logic s,
                                              input logic a, input logic [31:0] id,
                                              input logic [31:0] sq, input logic [31:0] an);
        hdr_event_t w;
        w.mode = m;
        w.checksum_ok = c;
        w.syn = s;
        w.ack = a;
        w.conn_id = id;
        w.seq = sq;
        w.ack_num = an;
        return w;
    endfunction

    function automatic hdr_event_t random_event();
        return make_event(1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          $urandom(), $urandom(), $urandom());
    endfunction

    function automatic result_t no_header(input logic [1:0] ph, input logic [2:0] vd);
        result_t r;
        r = '0;
        r.phase_now = ph;
        r.verdict = vd;
        return r;
    endfunction

    function automatic void clear_server_state();
        srv_phase = PHASE_LISTEN;
        srv_seq = '0;
        srv_conn_id = '0;
        srv_saved_seq = '0;
        srv_saved_acknum = '0;
        srv_tries = '0;
    endfunction

    // Works out the reply to one event and advances the tracked server state.
    function automatic result_t respond_to_event(input hdr_event_t ev);
        result_t    r;
        logic [3:0] limit;
        bit         failed;
        r = '0;
        r.verdict = VERDICT_OK;
        if (srv_phase == PHASE_SYNRCVD)
        begin
            failed = 1'b1;
            if (ev.mode)
            begin
                r.send_valid = 1'b1;
                r.tx_syn = 1'b1;
                r.tx_ack = 1'b1;
                r.tx_conn_id = srv_conn_id;
                r.tx_seq = srv_saved_seq;
                r.tx_acknum = srv_saved_acknum;
                r.verdict = VERDICT_RESENT;
            end
            else if (!ev.checksum_ok)
                r.verdict = VERDICT_CHECKSUM;
            else if (ev.conn_id != srv_conn_id)
                r.verdict = VERDICT_ID;
            else if (!ev.ack)
                r.verdict = VERDICT_FLAGS;
            else if (ev.ack_num != srv_seq)
                r.verdict = VERDICT_ACK;
            else
            begin
                failed = 1'b0;
                srv_phase = PHASE_EST;
                srv_tries = '0;
            end
            // Every failed event counts a try; the last one wipes the connection.
            if (failed)
            begin
                limit = (srv_patience == 4'd0) ? 4'd1 : srv_patience;
                srv_tries = srv_tries + 4'd1;
                if (srv_tries >= limit)
                begin
                    clear_server_state();
                    r = '0;
                    r.verdict = VERDICT_GAVEUP;
                end
            end
        end
        else if (srv_phase == PHASE_EST)
        begin
            if (ev.mode)
                r.verdict = VERDICT_IDLE;
            else if (!ev.checksum_ok)
                r.verdict = VERDICT_CHECKSUM;
            else if (ev.conn_id != srv_conn_id)
                r.verdict = VERDICT_ID;
            else
            begin
                r.deliver = 1'b1;
                r.send_valid = 1'b1;
                r.tx_ack = 1'b1;
                r.tx_conn_id = srv_conn_id;
                r.tx_seq = srv_seq;
                r.tx_acknum = ev.seq + 32'd1;
                srv_seq = srv_seq + 32'd1;
            end
        end
        else
        begin
            // Listen; an unknown phase code is treated the same way.
            if (ev.mode)
                r.verdict = VERDICT_IDLE;
            else if (!ev.checksum_ok)
                r.verdict = VERDICT_CHECKSUM;
            else if (!ev.syn || ev.ack)
                r.verdict = VERDICT_FLAGS;
            else
            begin
                srv_conn_id = ev.conn_id;
                r.send_valid = 1'b1;
                r.tx_syn = 1'b1;
                r.tx_ack = 1'b1;
                r.tx_conn_id = ev.conn_id;
                r.tx_seq = srv_seq;
                r.tx_acknum = ev.seq + 32'd1;
                srv_seq = srv_seq + 32'd1;
                srv_saved_seq = r.tx_seq;
                srv_saved_acknum = r.tx_acknum;
                srv_tries = '0;
                srv_phase = PHASE_SYNRCVD;
            end
        end
        r.phase_now = srv_phase;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Offers one word after a random gap and holds it until it is taken.
    task automatic send_word(input hdr_event_t w, input bit typed, input result_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        drv_event <= w;
        drv_typed <= typed;
        drv_want <= want;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Stops sending and waits until every reply has come back.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_patience(input logic [3:0] value);
        settle_idle();
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        srv_patience = value;
    endtask

    // Replies are checked first, then a newly taken word adds its expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                observed_reply = {send_valid, tx_syn, tx_ack, tx_conn_id, tx_seq, tx_acknum,
                                  deliver, phase_now, verdict};
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: reply 0x%0h arrived with none expected",
                             $time, observed_reply);
                    fail_count++;
                end
                else
                begin
                    predicted_reply = pending_replies.pop_front();
                    check_field("send_valid", 32'(predicted_reply.send_valid),
                                32'(observed_reply.send_valid));
                    check_field("tx_syn", 32'(predicted_reply.tx_syn),
                                32'(observed_reply.tx_syn));
                    check_field("tx_ack", 32'(predicted_reply.tx_ack),
                                32'(observed_reply.tx_ack));
                    check_field("tx_conn_id", predicted_reply.tx_conn_id,
                                observed_reply.tx_conn_id);
                    check_field("tx_seq", predicted_reply.tx_seq, observed_reply.tx_seq);
                    check_field("tx_acknum", predicted_reply.tx_acknum,
                                observed_reply.tx_acknum);
                    check_field("deliver", 32'(predicted_reply.deliver),
                                32'(observed_reply.deliver));
                    check_field("phase_now", 32'(predicted_reply.phase_now),
                                32'(observed_reply.phase_now));
                    check_field("verdict", 32'(predicted_reply.verdict),
                                32'(observed_reply.verdict));
                    results_checked++;
                end
            end
            if (in_valid && !in_stall)
            begin
                predicted_reply = respond_to_event(drv_event);
                if (drv_typed)
                    predicted_reply = drv_want;
                if (predicted_reply.verdict == VERDICT_RESENT)
                    resends_seen++;
                if (predicted_reply.verdict == VERDICT_GAVEUP)
                    give_ups_seen++;
                if (predicted_reply.deliver)
                    delivered_seen++;
                pending_replies.push_back(predicted_reply);
            end
        end
    end

    // Stimulus: directed rows, then random phases under several patience values.
    initial
    begin
        hdr_event_t w;
        int         pick;
        int         count;

        clear_server_state();
        srv_patience = PATIENCE_RESET;

        // Listen checks, a handshake that fails every way and gives up at patience 10.
        directed_rows[0] = '{make_event(1'b1, 1'b1, 1'b1, 1'b1, ONES, ONES, ONES), 1'b1,
                             no_header(PHASE_LISTEN, VERDICT_IDLE)};
        directed_rows[1] = '{make_event(1'b0, 1'b0, 1'b1, 1'b0, ONES, ONES, ONES), 1'b1,
                             no_header(PHASE_LISTEN, VERDICT_CHECKSUM)};
        directed_rows[2] = '{make_event(1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0), 1'b1,
                             no_header(PHASE_LISTEN, VERDICT_FLAGS)};
        directed_rows[3] = '{make_event(1'b0, 1'b1, 1'b1, 1'b1, ONES, 32'd0, 32'd0), 1'b1,
                             no_header(PHASE_LISTEN, VERDICT_FLAGS)};
        directed_rows[4] = '{make_event(1'b0, 1'b1, 1'b1, 1'b0, ONES, ONES, 32'd0), 1'b1,
                             '{1'b1, 1'b1, 1'b1, ONES, 32'd0, 32'd0, 1'b0,
                               PHASE_SYNRCVD, VERDICT_OK}};
        directed_rows[5] = '{make_event(1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0), 1'b1,
                             '{1'b1, 1'b1, 1'b1, ONES, 32'd0, 32'd0, 1'b0,
                               PHASE_SYNRCVD, VERDICT_RESENT}};
        directed_rows[6] = '{make_event(1'b0, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd1), 1'b1,
                             no_header(PHASE_SYNRCVD, VERDICT_CHECKSUM)};
        directed_rows[7] = '{make_event(1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd1), 1'b1,
                             no_header(PHASE_SYNRCVD, VERDICT_ID)};
        directed_rows[8] = '{make_event(1'b0, 1'b1, 1'b1, 1'b0, ONES, 32'd0, 32'd1), 1'b1,
                             no_header(PHASE_SYNRCVD, VERDICT_FLAGS)};
        directed_rows[9] = '{make_event(1'b0, 1'b1, 1'b0, 1'b1, ONES, 32'd0, 32'd0), 1'b1,
                             no_header(PHASE_SYNRCVD, VERDICT_ACK)};
        directed_rows[10] = '{make_event(1'b0, 1'b1, 1'b1, 1'b1, ONES, ONES, ONES), 1'b1,
                              no_header(PHASE_SYNRCVD, VERDICT_ACK)};
        for (int i = 11; i < 14; i++)
            directed_rows[i] = '{make_event(1'b1, 1'b1, 1'b1, 1'b1, ONES, ONES, ONES), 1'b1,
                                 '{1'b1, 1'b1, 1'b1, ONES, 32'd0, 32'd0, 1'b0,
                                   PHASE_SYNRCVD, VERDICT_RESENT}};
        // The tenth failed event is a resend, reported as giving up instead.
        directed_rows[14] = '{make_event(1'b1, 1'b1, 1'b0, 1'b0, ONES, 32'd0, 32'd0), 1'b1,
                              no_header(PHASE_LISTEN, VERDICT_GAVEUP)};
        directed_rows[15] = '{make_event(1'b0, 1'b1, 1'b1, 1'b0, 32'h5A5A_A5A5,
                                         32'h8000_0000, ONES), 1'b0, '0};
        // From a cleared listen state: connect, then the established cases.
        directed_rows[16] = '{make_event(1'b0, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0, ONES), 1'b1,
                              '{1'b1, 1'b1, 1'b1, 32'd0, 32'd0, 32'd1, 1'b0,
                                PHASE_SYNRCVD, VERDICT_OK}};
        directed_rows[17] = '{make_event(1'b0, 1'b1, 1'b0, 1'b1, 32'd0, ONES, 32'd1), 1'b1,
                              no_header(PHASE_EST, VERDICT_OK)};
        directed_rows[18] = '{make_event(1'b1, 1'b1, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0), 1'b1,
                              no_header(PHASE_EST, VERDICT_IDLE)};
        directed_rows[19] = '{make_event(1'b0, 1'b0, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0), 1'b1,
                              no_header(PHASE_EST, VERDICT_CHECKSUM)};
        directed_rows[20] = '{make_event(1'b0, 1'b1, 1'b0, 1'b1, ONES, 32'd0, 32'd0), 1'b1,
                              no_header(PHASE_EST, VERDICT_ID)};
        directed_rows[21] = '{make_event(1'b0, 1'b1, 1'b1, 1'b1, 32'd0, ONES, ONES), 1'b1,
                              '{1'b1, 1'b0, 1'b1, 32'd0, 32'd1, 32'd0, 1'b1,
                                PHASE_EST, VERDICT_OK}};
        directed_rows[22] = '{make_event(1'b0, 1'b1, 1'b0, 1'b0, 32'd0, 32'h1234_5678, 32'd0),
                              1'b0, '0};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < EST_FIRST_ROW; i++)
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
                write_patience(4'($urandom_range(1, 15)));
            else
                write_patience(PATIENCE_PLAN[ph]);
            // The second phase runs with neither side ever idling.
            idle_pct = (ph == 1) ? 0 : 26;
            count = 150;
            if (ph == PHASES - 1)
            begin
                // Time out of any open handshake, then connect for good.
                while (srv_phase != PHASE_LISTEN)
                begin
                    w = random_event();
                    w.mode = 1'b1;
                    send_word(w, 1'b0, '0);
                end
                for (int i = EST_FIRST_ROW; i < DIRECTED_ROWS; i++)
                    send_word(directed_rows[i].word, directed_rows[i].typed,
                              directed_rows[i].want);
                count = 200;
            end
            for (int n = 0; n < count; n++)
            begin
                w = random_event();
                pick = $urandom_range(99);
                case (srv_phase)
                    PHASE_LISTEN:
                    begin
                        if (pick < 75)
                        begin
                            w.mode = 1'b0;
                            w.checksum_ok = 1'b1;
                            w.syn = 1'b1;
                            w.ack = 1'b0;
                        end
                        else if (pick < 85)
                            w.mode = 1'b1;
                    end
                    PHASE_SYNRCVD:
                    begin
                        // Every failure kind; a matching ACK is never built here.
                        w.mode = 1'b0;
                        w.checksum_ok = 1'b1;
                        if (pick < 22)
                            w.mode = 1'b1;
                        else if (pick < 36)
                            w.checksum_ok = 1'b0;
                        else if (pick < 50)
                            w.conn_id = srv_conn_id ^ (32'd1 << $urandom_range(31));
                        else if (pick < 64)
                        begin
                            w.conn_id = srv_conn_id;
                            w.ack = 1'b0;
                        end
                        else if (pick < 90)
                        begin
                            w.conn_id = srv_conn_id;
                            w.ack = 1'b1;
                            case ($urandom_range(2))
                                0: w.ack_num = srv_seq + 32'd1;
                                1: w.ack_num = srv_seq - 32'd1;
                                default: w.ack_num = srv_seq ^ (32'd1 << $urandom_range(31));
                            endcase
                        end
                        else
                            w.mode = 1'($urandom_range(1));
                    end
                    default:
                    begin
                        w.mode = 1'b0;
                        w.checksum_ok = 1'b1;
                        if (pick < 55)
                            w.conn_id = srv_conn_id;
                        else if (pick < 65)
                            w.mode = 1'b1;
                        else if (pick < 75)
                            w.checksum_ok = 1'b0;
                        else if (pick < 85)
                            w.conn_id = srv_conn_id ^ (32'd1 << $urandom_range(31));
                        else
                            w.mode = 1'($urandom_range(1));
                    end
                endcase
                send_word(w, 1'b0, '0);
            end
        end

        settle_idle();
        $display("Sent %0d words through listen, handshake and established traffic", words_sent);
        $display("under patience 10, 1, 15, 0, 4 and a random value: %0d replies, %0d resends,",
                 results_checked, resends_seen);
        $display("%0d give-ups and %0d delivered.", give_ups_seen, delivered_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== handshake_server_responder.f =====
rtl/core/hsr_pkg.sv
rtl/core/handshake_server_responder.sv
rtl/core/hsr_checker.sv
bench/handshake_server_responder_tb.sv
